// File: src/vec2_rotate_normalize_unit_macros.svh
// assertion macros for the vec2 rotate / normalize unit checker
// bodies expect i_clk and i_rst_n in the scope of use
`ifndef VEC2_ROTATE_NORMALIZE_UNIT_MACROS_SVH
`define VEC2_ROTATE_NORMALIZE_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define VRN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define VRN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vrn_pkg.sv
// shared types and constants for the vec2 rotate / normalize unit
// no dependencies
package vrn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ITERATIONS = 24;
    localparam int GUARD      = 16;

    localparam int AW = 34;
    localparam int CW = 32 + GUARD + 2;
    localparam int QB = FRAC_BITS + 1;
    localparam int DW = 32 + FRAC_BITS + 2;

    localparam logic signed [AW-1:0] ANG_PI      = AW'(64'sd843314857);
    localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(64'sd421657428);
    localparam logic signed [AW-1:0] ANG_TWO_PI  = AW'(64'sd1686629713);
    localparam logic signed [30:0]   KGAIN_Q30   = 31'sd652032874;

    localparam logic signed [AW-1:0] ATAN_TAB [10] = '{
        AW'(64'sd210828714), AW'(64'sd124459457), AW'(64'sd65760959),
        AW'(64'sd33381290),  AW'(64'sd16755422),  AW'(64'sd8385879),
        AW'(64'sd4193963),   AW'(64'sd2097109),   AW'(64'sd1048571),
        AW'(64'sd524287)
    };

    typedef enum logic [1:0] {
        REQ_ROTATE    = 2'd0,
        REQ_NORMALIZE = 2'd1,
        REQ_LENGTH    = 2'd2,
        REQ_LENGTH_SQ = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] angle;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [31:0]        magnitude;
        logic               zero_vector;
        logic               saturated;
    } t_res;

    function automatic logic signed [AW-1:0] atan_step(input int i);
        logic signed [AW-1:0] v;
        v = '0;
        if (i < 10) begin
            v = ATAN_TAB[i[3:0]];
        end else if (i <= 28) begin
            v[6'(28 - i)] = 1'b1;
        end
        return v;
    endfunction

endpackage

// File: src/vrn_pipe.sv
// datapath pipeline: angle fold, cordic, squares, root, divider, result select
// depends on vrn_pkg
module vrn_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  vrn_pkg::t_req i_req,
    output logic          o_valid,
    output vrn_pkg::t_res o_res
);
    import vrn_pkg::*;

    localparam int S_ROT0  = 3;
    localparam int S_SQ2   = 4;
    localparam int S_RAD   = 5;
    localparam int S_RT0   = 6;
    localparam int RT_STEPS = 32;
    localparam int S_RND   = S_RT0 + RT_STEPS;
    localparam int S_DIVI  = S_RND + 1;
    localparam int S_DV0   = S_DIVI + 1;
    localparam int NS      = S_DV0 + QB;

    localparam logic signed [CW-1:0] RND_HALF = CW'(64'sd1) <<< (GUARD - 1);
    localparam logic signed [CW-1:0] MAXV     = CW'(64'sd2147483647);
    localparam logic signed [CW-1:0] MINV     = CW'(-64'sd2147483648);

    typedef struct packed {
        t_req_type            op;
        logic                 neg_x;
        logic                 neg_y;
        logic                 zero;
        logic signed [AW-1:0] ang;
        logic signed [32:0]   xs;
        logic signed [32:0]   ys;
        logic [31:0]          ax;
        logic [31:0]          ay;
        logic [31:0]          mx;
        logic [4:0]           sh;
        logic [63:0]          sqx;
        logic [63:0]          sqy;
        logic [63:0]          sum;
        logic [31:0]          lsq;
        logic                 lsq_sat;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [63:0]          rad;
        logic [63:0]          res;
        logic [32:0]          root;
        logic [DW-1:0]        remx;
        logic [DW-1:0]        remy;
        logic [QB-1:0]        qx;
        logic [QB-1:0]        qy;
    } t_stage;

    t_stage          r_s [NS];
    t_stage          n_s [NS];
    logic [NS-1:0]   r_vld;

    function automatic logic [32:0] clip_round(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic [32:0]          o;
        t = v + RND_HALF;
        t = t >>> GUARD;
        if (t > MAXV) begin
            o = {1'b1, MAXV[31:0]};
        end else if (t < MINV) begin
            o = {1'b1, MINV[31:0]};
        end else begin
            o = {1'b0, t[31:0]};
        end
        return o;
    endfunction

    // input decode, abs values, angle wrap
    always_comb begin
        logic signed [AW-1:0] a0;
        n_s[0]       = '0;
        a0           = {{(AW-32){i_req.angle[31]}}, i_req.angle};
        n_s[0].op    = i_req.req_type;
        n_s[0].neg_x = i_req.in_x[31];
        n_s[0].neg_y = i_req.in_y[31];
        n_s[0].zero  = (i_req.in_x == 32'sd0) && (i_req.in_y == 32'sd0);
        n_s[0].xs    = {i_req.in_x[31], i_req.in_x};
        n_s[0].ys    = {i_req.in_y[31], i_req.in_y};
        n_s[0].ax    = i_req.in_x[31] ? 32'(-i_req.in_x) : 32'(i_req.in_x);
        n_s[0].ay    = i_req.in_y[31] ? 32'(-i_req.in_y) : 32'(i_req.in_y);
        if (a0 > ANG_PI) begin
            n_s[0].ang = a0 - ANG_TWO_PI;
        end else if (a0 < -ANG_PI) begin
            n_s[0].ang = a0 + ANG_TWO_PI;
        end else begin
            n_s[0].ang = a0;
        end
    end

    for (genvar g = 1; g < NS; g++) begin : g_stage
        localparam int CI = (g >= S_ROT0 && g < S_ROT0 + ITERATIONS) ? g - S_ROT0 : 0;
        localparam int RK = (g >= S_RT0 && g < S_RT0 + RT_STEPS) ? g - S_RT0 : 0;
        localparam int DJ = (g >= S_DV0 && g < S_DV0 + QB) ? QB - 1 - (g - S_DV0) : 0;
        localparam logic signed [AW-1:0] AT   = atan_step(CI);
        localparam logic [63:0]          RBIT = 64'd1 << (62 - 2 * RK);

        always_comb begin
            t_stage             p;
            logic signed [63:0] px;
            logic signed [63:0] py;
            logic [63:0]        t;
            logic [63:0]        q;
            logic [4:0]         hi;
            logic [DW-1:0]      dvs;
            p      = r_s[g-1];
            n_s[g] = p;
            px     = '0;
            py     = '0;
            t      = '0;
            q      = '0;
            hi     = '0;
            dvs    = '0;

            if (g == 1) begin
                if (p.ang > ANG_HALF_PI) begin
                    n_s[g].ang = p.ang - ANG_PI;
                    n_s[g].xs  = -p.xs;
                    n_s[g].ys  = -p.ys;
                end else if (p.ang < -ANG_HALF_PI) begin
                    n_s[g].ang = p.ang + ANG_PI;
                    n_s[g].xs  = -p.xs;
                    n_s[g].ys  = -p.ys;
                end
                n_s[g].mx  = (p.ax > p.ay) ? p.ax : p.ay;
                n_s[g].sqx = p.ax * p.ax;
                n_s[g].sqy = p.ay * p.ay;
            end

            if (g == 2) begin
                px = p.xs * KGAIN_Q30;
                py = p.ys * KGAIN_Q30;
                n_s[g].cx  = CW'(px >>> (30 - GUARD));
                n_s[g].cy  = CW'(py >>> (30 - GUARD));
                n_s[g].sum = p.sqx + p.sqy;
                for (int b = 0; b < 32; b++) begin
                    if (p.mx[b]) begin
                        hi = 5'(b);
                    end
                end
                n_s[g].sh = (p.mx[31] || p.mx[30]) ? 5'd0 : 5'd30 - hi;
            end

            if (g == 3) begin
                t = p.sum + (64'd1 << (FRAC_BITS - 1));
                q = t >> FRAC_BITS;
                if (q[63:32] != 32'd0) begin
                    n_s[g].lsq     = '1;
                    n_s[g].lsq_sat = 1'b1;
                end else begin
                    n_s[g].lsq     = q[31:0];
                    n_s[g].lsq_sat = 1'b0;
                end
                n_s[g].ax = p.ax << p.sh;
                n_s[g].ay = p.ay << p.sh;
            end

            if (g >= S_ROT0 && g < S_ROT0 + ITERATIONS) begin
                if (p.ang >= 0) begin
                    n_s[g].cx  = p.cx - (p.cy >>> CI);
                    n_s[g].cy  = p.cy + (p.cx >>> CI);
                    n_s[g].ang = p.ang - AT;
                end else begin
                    n_s[g].cx  = p.cx + (p.cy >>> CI);
                    n_s[g].cy  = p.cy - (p.cx >>> CI);
                    n_s[g].ang = p.ang + AT;
                end
            end

            if (g == S_SQ2) begin
                n_s[g].sqx = p.ax * p.ax;
                n_s[g].sqy = p.ay * p.ay;
            end

            if (g == S_RAD) begin
                n_s[g].rad = (p.op == REQ_NORMALIZE) ? p.sqx + p.sqy : p.sum;
                n_s[g].res = '0;
            end

            if (g >= S_RT0 && g < S_RT0 + RT_STEPS) begin
                t = p.res + RBIT;
                if (p.rad >= t) begin
                    n_s[g].rad = p.rad - t;
                    n_s[g].res = (p.res >> 1) + RBIT;
                end else begin
                    n_s[g].res = p.res >> 1;
                end
            end

            if (g == S_RND) begin
                n_s[g].root = (p.rad > p.res) ? p.res[32:0] + 33'd1 : p.res[32:0];
            end

            if (g == S_DIVI) begin
                n_s[g].remx = (DW'(p.ax) << (FRAC_BITS + 1)) + DW'(p.root);
                n_s[g].remy = (DW'(p.ay) << (FRAC_BITS + 1)) + DW'(p.root);
                n_s[g].qx   = '0;
                n_s[g].qy   = '0;
            end

            if (g >= S_DV0 && g < S_DV0 + QB) begin
                dvs = DW'(p.root) << (DJ + 1);
                if (p.remx >= dvs) begin
                    n_s[g].remx    = p.remx - dvs;
                    n_s[g].qx[DJ]  = 1'b1;
                end
                if (p.remy >= dvs) begin
                    n_s[g].remy    = p.remy - dvs;
                    n_s[g].qy[DJ]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    // result select
    always_comb begin
        t_stage      p;
        logic [32:0] cxr;
        logic [32:0] cyr;
        p     = r_s[NS-1];
        cxr   = clip_round(p.cx);
        cyr   = clip_round(p.cy);
        o_res = '0;
        case (p.op)
            REQ_ROTATE: begin
                o_res.out_x     = cxr[31:0];
                o_res.out_y     = cyr[31:0];
                o_res.saturated = cxr[32] | cyr[32];
            end
            REQ_NORMALIZE: begin
                if (p.zero) begin
                    o_res.zero_vector = 1'b1;
                end else begin
                    o_res.out_x = p.neg_x ? -(32'(p.qx)) : 32'(p.qx);
                    o_res.out_y = p.neg_y ? -(32'(p.qy)) : 32'(p.qy);
                end
            end
            REQ_LENGTH: begin
                o_res.magnitude = p.root[31:0];
            end
            REQ_LENGTH_SQ: begin
                o_res.magnitude = p.lsq;
                o_res.saturated = p.lsq_sat;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    assign o_valid = r_vld[NS-1];

endmodule

// File: src/vec2_rotate_normalize_unit.sv
// throughput: one transaction per cycle while the output is not stalled; depth set by the 32-step square root
// and the 17-step restoring divider in series behind the squaring stages
// synchronous active-low reset clears the valid bits; the pipeline stalls as a whole
// top level: handshake and output register around vrn_pipe, depends on vrn_pkg
module vec2_rotate_normalize_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  vrn_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output vrn_pkg::t_res o_out_data
);
    import vrn_pkg::*;

    logic r_ovld;
    t_res r_odata;
    logic en;
    logic pipe_valid;
    t_res pipe_res;

    assign en = !r_ovld || i_out_ready;

    vrn_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_req   (i_in_data),
        .o_valid (pipe_valid),
        .o_res   (pipe_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= pipe_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= pipe_res;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

endmodule

// File: src/vrn_checker.sv
// port-level checker for the vec2 rotate / normalize unit, bound to the top level
// depends on vrn_pkg and vec2_rotate_normalize_unit_macros.svh
`include "vec2_rotate_normalize_unit_macros.svh"

module vrn_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input vrn_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input vrn_pkg::t_res o_out_data
);
    import vrn_pkg::*;

    `VRN_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `VRN_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data), "result changed while stalled")
    `VRN_ASSERT_SAME(a_ready_free, !o_out_valid || i_out_ready, o_in_ready, "input stalled with free output")
    `VRN_ASSERT_SAME(a_zero_clean, o_out_valid && o_out_data.zero_vector, o_out_data.out_x == 32'sd0 && o_out_data.out_y == 32'sd0 && o_out_data.magnitude == 32'd0 && !o_out_data.saturated, "zero vector result not clean")
    `VRN_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data), "input transaction changed while waiting")

endmodule

bind vec2_rotate_normalize_unit vrn_checker u_vrn_checker (.*);

// File: dv/testbench.sv
// self-checking testbench for vec2_rotate_normalize_unit: directed table, then random transactions
// results are checked against typed rows or a behavioral predictor of all four request types
// depends on vrn_pkg and the vec2_rotate_normalize_unit rtl
module testbench;
    import vrn_pkg::*;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_stim_row;

    localparam int  NUM_RANDOM  = 1700;
    localparam int  QUIET_TAIL  = 200;
    localparam int  DRAIN_WAIT  = 70;
    localparam int  STALL_LIMIT = 4000;
    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sd65536;
    localparam logic signed [31:0] A_PI = 32'sd843314857;
    localparam logic signed [31:0] A_HP = 32'sd421657428;

    localparam longint ROT_GAIN = 64'sd652032874;
    localparam longint ROT_PI   = 64'sd843314857;
    localparam longint ROT_HP   = 64'sd421657428;
    localparam longint ROT_2PI  = 64'sd1686629713;
    localparam longint ARC_TAB [10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                                       8385879, 4193963, 2097109, 1048571, 524287};

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_res o_out_data;

    t_res pending_results[$];
    bit   failed;
    bit   quiet;
    int   sink_stall;
    int   idle_cycles;

    t_stim_row directed_tab [] = '{
        '{'{REQ_LENGTH, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b0, 1'b0}},
        '{'{REQ_LENGTH, 32'sd3, 32'sd4, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'd5, 1'b0, 1'b0}},
        '{'{REQ_LENGTH_SQ, 32'sd0, 32'sd0, SMAX}, 1'b1,
          '{32'sd0, 32'sd0, 32'd0, 1'b0, 1'b0}},
        '{'{REQ_LENGTH_SQ, SMIN, SMIN, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, 32'hffffffff, 1'b0, 1'b1}},
        '{'{REQ_LENGTH_SQ, SMAX, SMAX, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, 32'hffffffff, 1'b0, 1'b1}},
        '{'{REQ_NORMALIZE, 32'sd0, 32'sd0, SMIN}, 1'b1,
          '{32'sd0, 32'sd0, 32'd0, 1'b1, 1'b0}},
        '{'{REQ_LENGTH, SMIN, SMIN, 32'sd0}, 1'b0, '0},
        '{'{REQ_LENGTH, SMAX, SMIN, 32'sd0}, 1'b0, '0},
        '{'{REQ_LENGTH_SQ, ONE, -ONE, 32'sd0}, 1'b0, '0},
        '{'{REQ_NORMALIZE, ONE, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{REQ_NORMALIZE, 32'sd1, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{REQ_NORMALIZE, 32'sd0, -32'sd1, 32'sd0}, 1'b0, '0},
        '{'{REQ_NORMALIZE, SMIN, SMIN, 32'sd0}, 1'b0, '0},
        '{'{REQ_NORMALIZE, SMAX, SMIN, 32'sd0}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, ONE, A_PI}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, -ONE, -A_PI}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, 32'sd0, A_PI + 32'sd1}, 1'b0, '0},
        '{'{REQ_ROTATE, 32'sd0, ONE, -A_PI - 32'sd1}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, ONE, SMAX}, 1'b0, '0},
        '{'{REQ_ROTATE, -ONE, ONE, SMIN}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, 32'sd0, A_HP}, 1'b0, '0},
        '{'{REQ_ROTATE, ONE, 32'sd0, -A_HP - 32'sd1}, 1'b0, '0},
        '{'{REQ_ROTATE, SMIN, SMIN, 32'sd210828714}, 1'b0, '0},
        '{'{REQ_ROTATE, SMAX, SMAX, -32'sd210828714}, 1'b0, '0}
    };

    vec2_rotate_normalize_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint unsigned root_nearest(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned v;
        res  = 0;
        bitv = 64'd1 << 62;
        v    = n;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v > res) res++;
        return res;
    endfunction

    function automatic longint arc_step(int i);
        if (i < 10) return ARC_TAB[i];
        if (i <= 28) return 64'sd1 <<< (28 - i);
        return 0;
    endfunction

    function automatic logic signed [31:0] clip_s32(longint v, ref bit sat);
        if (v > longint'(SMAX)) begin
            sat = 1'b1;
            return SMAX;
        end
        if (v < longint'(SMIN)) begin
            sat = 1'b1;
            return SMIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] unit_component(longint unsigned mag, bit neg,
                                                          longint unsigned rt, ref bit sat);
        longint unsigned q;
        q = ((mag << (FRAC_BITS + 1)) + rt) / (rt << 1);
        return clip_s32(neg ? -longint'(q) : longint'(q), sat);
    endfunction

    function automatic t_res predict_result(t_req r);
        longint sx, sy, sa, xr, yr, dx, dy;
        longint unsigned ax, ay, sum, m, rt, q;
        bit sat;
        t_res o;
        o   = '0;
        sat = 1'b0;
        sx  = r.in_x;
        sy  = r.in_y;
        sa  = r.angle;
        ax  = (sx < 0) ? -sx : sx;
        ay  = (sy < 0) ? -sy : sy;
        sum = ax * ax + ay * ay;
        case (r.req_type)
            REQ_ROTATE: begin
                if (sa > ROT_PI) sa = sa - ROT_2PI;
                if (sa < -ROT_PI) sa = sa + ROT_2PI;
                if (sa > ROT_HP) begin
                    sa = sa - ROT_PI;
                    sx = -sx;
                    sy = -sy;
                end else if (sa < -ROT_HP) begin
                    sa = sa + ROT_PI;
                    sx = -sx;
                    sy = -sy;
                end
                xr = (sx * ROT_GAIN) >>> (30 - GUARD);
                yr = (sy * ROT_GAIN) >>> (30 - GUARD);
                for (int i = 0; i < ITERATIONS; i++) begin
                    dx = yr >>> i;
                    dy = xr >>> i;
                    if (sa >= 0) begin
                        xr = xr - dx;
                        yr = yr + dy;
                        sa = sa - arc_step(i);
                    end else begin
                        xr = xr + dx;
                        yr = yr - dy;
                        sa = sa + arc_step(i);
                    end
                end
                o.out_x = clip_s32((xr + (64'sd1 <<< (GUARD - 1))) >>> GUARD, sat);
                o.out_y = clip_s32((yr + (64'sd1 <<< (GUARD - 1))) >>> GUARD, sat);
            end
            REQ_NORMALIZE: begin
                if (sum == 0) begin
                    o.zero_vector = 1'b1;
                end else begin
                    m = (ax > ay) ? ax : ay;
                    while (m < (64'd1 << 30)) begin
                        m  = m << 1;
                        ax = ax << 1;
                        ay = ay << 1;
                    end
                    rt = root_nearest(ax * ax + ay * ay);
                    o.out_x = unit_component(ax, sx < 0, rt, sat);
                    o.out_y = unit_component(ay, sy < 0, rt, sat);
                end
            end
            REQ_LENGTH: begin
                o.magnitude = root_nearest(sum);
            end
            default: begin
                q = (sum + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                if (q > 64'hffffffff) begin
                    q   = 64'hffffffff;
                    sat = 1'b1;
                end
                o.magnitude = q[31:0];
            end
        endcase
        o.saturated = sat;
        return o;
    endfunction

    function automatic logic signed [31:0] pick_component();
        case ($urandom_range(0, 5))
            0: return SMAX - $urandom_range(0, 3);
            1: return SMIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 1 << 20) - (1 << 19);
            3: return $urandom_range(0, 1 << 8) - (1 << 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_req r, bit typed, t_res e, bit idle_ok);
        int gap;
        if (idle_ok && !quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(typed ? e : predict_result(r));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic check_result(t_res got);
        t_res want;
        want = pending_results.pop_front();
        if (got.out_x !== want.out_x) begin
            $display("%0t out_x expected %h actual %h", $time, want.out_x, got.out_x);
            failed = 1'b1;
        end
        if (got.out_y !== want.out_y) begin
            $display("%0t out_y expected %h actual %h", $time, want.out_y, got.out_y);
            failed = 1'b1;
        end
        if (got.magnitude !== want.magnitude) begin
            $display("%0t magnitude expected %h actual %h", $time, want.magnitude,
                     got.magnitude);
            failed = 1'b1;
        end
        if (got.zero_vector !== want.zero_vector) begin
            $display("%0t zero_vector expected %b actual %b", $time, want.zero_vector,
                     got.zero_vector);
            failed = 1'b1;
        end
        if (got.saturated !== want.saturated) begin
            $display("%0t saturated expected %b actual %b", $time, want.saturated,
                     got.saturated);
            failed = 1'b1;
        end
    endtask

    // result side: compare each accepted transaction, random back-pressure bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_out_data);
                failed = 1'b1;
            end else begin
                check_result(o_out_data);
            end
        end
        if (sink_stall > 0) begin
            sink_stall  <= sink_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            sink_stall  <= $urandom_range(0, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_req r;
        failed      = 1'b0;
        quiet       = 1'b0;
        sink_stall  = 0;
        idle_cycles = 0;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tab[i])
            send(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].res, 1'b1);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
            r.req_type = t_req_type'($urandom_range(0, 3));
            r.in_x     = pick_component();
            r.in_y     = pick_component();
            r.angle    = ($urandom_range(0, 1) == 0) ? $urandom
                       : $urandom_range(0, 2 * A_PI) - A_PI;
            send(r, 1'b0, '0, 1'b1);
        end
        i_in_valid <= 1'b0;
        wait_drained();

        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
